// ===== rtl/kars_pkg.sv =====
// ----------------------------------------------------------------------------
// kars_pkg: key auto-repeat scanner package
// Shared widths, register indexes, reset values and the scan sequencer states.
// ----------------------------------------------------------------------------
package kars_pkg;

  localparam int NUM_KEYS_DEF = 14;

  localparam int HELD_W  = 14;
  localparam int CFG_W   = 10;
  localparam int COUNT_W = 11;
  localparam int KEY_W   = 4;
  localparam int REG_W   = 1;

  // register indexes on the configuration port
  localparam logic [REG_W-1:0] REG_REPEAT_DELAY = 1'b0;
  localparam logic [REG_W-1:0] REG_REPEAT_RATE  = 1'b1;

  localparam logic [CFG_W-1:0] DELAY_RST = 10'd30;
  localparam logic [CFG_W-1:0] RATE_RST  = 10'd10;

  localparam logic EV_PRESS   = 1'b0;
  localparam logic EV_RELEASE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } scan_state_e;

endpackage

// ===== rtl/key_auto_repeat_scanner.sv =====
// ----------------------------------------------------------------------------
// key_auto_repeat_scanner: typematic press, repeat and release event scanner
// Walks held keys one per cycle unless stalled and emits key events in order.
// ----------------------------------------------------------------------------
// A frame sample is taken on in_valid_i/in_ready_o; the block then walks the
// keys from index 0 upwards, one key per cycle while the walk is not stalled,
// through a single compare and increment unit that checks the key's hold
// count against the delay and the delay plus rate, and updates the count. The
// walk stalls while the output side holds off a transfer and a further event
// is ready. Events leave through a one-entry output register with one more
// event held behind it, so the final event of a frame can carry last_event_o.
// A frame that produces no events produces no transfers. repeat_delay and
// repeat_rate must be written through cfg_we_i only while the block is idle;
// the block itself does not enforce this. A rate of zero acts as one.
module key_auto_repeat_scanner #(
  parameter int NUM_KEYS = kars_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_we_i,
  input  logic [kars_pkg::REG_W-1:0]  cfg_idx_i,
  input  logic [kars_pkg::CFG_W-1:0]  cfg_wdata_i,

  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic [kars_pkg::HELD_W-1:0] held_keys_i,

  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [kars_pkg::KEY_W-1:0]  key_index_o,
  output logic                        event_kind_o,
  output logic                        last_event_o
);

  localparam int IdxW = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int ExtW = (NUM_KEYS > kars_pkg::HELD_W) ? NUM_KEYS : kars_pkg::HELD_W;
  localparam int CntW = kars_pkg::COUNT_W;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(NUM_KEYS - 1);

  kars_pkg::scan_state_e state_q, state_d;

  logic [kars_pkg::CFG_W-1:0] delay_q, rate_q;
  logic [CntW-1:0]            top_q;
  logic [NUM_KEYS-1:0]        held_q, prev_q;
  logic [CntW-1:0]            cnt_q [NUM_KEYS];
  logic [IdxW-1:0]            idx_q;

  logic                       pend_valid_q, pend_valid_d;
  logic [IdxW-1:0]            pend_key_q, pend_key_d;
  logic                       pend_kind_q, pend_kind_d;

  logic                       out_valid_q, out_valid_d;
  logic [kars_pkg::KEY_W-1:0] out_key_q, out_key_d;
  logic                       out_kind_q, out_kind_d;
  logic                       out_last_q, out_last_d;

  logic [ExtW-1:0]            held_ext;
  logic                       in_xfer;
  logic [CntW-1:0]            cnt_cur, cnt_nxt, delay_ext;
  logic                       key_now, key_before;
  logic                       ev, ev_kind;
  logic                       out_free, stall, advance;
  logic                       push_mid, push_end;

  assign held_ext = ExtW'(held_keys_i);
  assign in_xfer  = in_valid_i && in_ready_o;

  // shared compare / increment unit working on the key under the scan index
  assign cnt_cur    = cnt_q[idx_q];
  assign key_now    = held_q[idx_q];
  assign key_before = prev_q[idx_q];
  assign delay_ext  = CntW'(delay_q);

  always_comb begin
    ev      = 1'b0;
    ev_kind = kars_pkg::EV_PRESS;
    cnt_nxt = '0;
    if (!key_now) begin
      ev      = key_before;
      ev_kind = kars_pkg::EV_RELEASE;
    end else begin
      ev = (cnt_cur == '0) || ((cnt_cur > delay_ext) && (cnt_cur == top_q));
      if (cnt_cur >= top_q) begin
        cnt_nxt = delay_ext + CntW'(1);
      end else begin
        cnt_nxt = cnt_cur + CntW'(1);
      end
    end
  end

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      kars_pkg::ST_IDLE: begin
        if (in_xfer) state_d = kars_pkg::ST_SCAN;
      end
      kars_pkg::ST_SCAN: begin
        if (advance && (idx_q == LastIdx)) state_d = kars_pkg::ST_FLUSH;
      end
      kars_pkg::ST_FLUSH: begin
        if (!pend_valid_q || out_free) state_d = kars_pkg::ST_IDLE;
      end
      default: state_d = kars_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready_o = 1'b0;
    stall      = 1'b0;
    advance    = 1'b0;
    push_mid   = 1'b0;
    push_end   = 1'b0;
    case (state_q)
      kars_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
      end
      kars_pkg::ST_SCAN: begin
        stall    = ev && pend_valid_q && !out_free;
        advance  = !stall;
        push_mid = advance && ev && pend_valid_q;
      end
      kars_pkg::ST_FLUSH: begin
        push_end = pend_valid_q && out_free;
      end
      default: in_ready_o = 1'b0;
    endcase
  end

  // held-back event and output register
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_key_d   = pend_key_q;
    pend_kind_d  = pend_kind_q;
    if (advance && ev) begin
      pend_valid_d = 1'b1;
      pend_key_d   = idx_q;
      pend_kind_d  = ev_kind;
    end else if (push_end) begin
      pend_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q && !out_ready_i;
    out_key_d   = out_key_q;
    out_kind_d  = out_kind_q;
    out_last_d  = out_last_q;
    if (push_mid || push_end) begin
      out_valid_d = 1'b1;
      out_key_d   = kars_pkg::KEY_W'(pend_key_q);
      out_kind_d  = pend_kind_q;
      out_last_d  = push_end;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= kars_pkg::ST_IDLE;
      delay_q      <= kars_pkg::DELAY_RST;
      rate_q       <= kars_pkg::RATE_RST;
      prev_q       <= '0;
      idx_q        <= '0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      state_q      <= state_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          kars_pkg::REG_REPEAT_DELAY: delay_q <= cfg_wdata_i;
          kars_pkg::REG_REPEAT_RATE:  rate_q  <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (in_xfer) begin
        idx_q <= '0;
      end else if (advance) begin
        idx_q <= idx_q + IdxW'(1);
        cnt_q[idx_q] <= cnt_nxt;
        if (idx_q == LastIdx) prev_q <= held_q;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      held_q <= held_ext[NUM_KEYS-1:0];
      top_q  <= CntW'(delay_q) + ((rate_q == '0) ? CntW'(1) : CntW'(rate_q));
    end
    pend_key_q  <= pend_key_d;
    pend_kind_q <= pend_kind_d;
    out_key_q   <= out_key_d;
    out_kind_q  <= out_kind_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o  = out_valid_q;
  assign key_index_o  = out_key_q;
  assign event_kind_o = out_kind_q;
  assign last_event_o = out_last_q;

  // a held-back event only exists while a frame is being worked on
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (state_q != kars_pkg::ST_IDLE))
    else $error("held-back event left over after frame end");

  // a new frame always starts the walk at key zero with nothing held back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> ((state_q == kars_pkg::ST_SCAN) && (idx_q == '0) && !pend_valid_q))
    else $error("scan did not start cleanly");

  // the scan index never moves while the walk is stalled on the output side
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == kars_pkg::ST_SCAN) && stall) |=> (idx_q == $past(idx_q)))
    else $error("scan index moved during a stall");

endmodule

// ===== bench/key_event_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_event_checker: scoreboard for the key auto-repeat scanner
// Watches the configuration port and both channels, keeps its own copy of the
// per-key hold counts and works out the press, repeat and release events of
// every accepted frame, then compares each event transfer in arrival order.
// ----------------------------------------------------------------------------
module key_event_checker #(
  parameter int NUM_KEYS = kars_pkg::NUM_KEYS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,

  input  logic                        cfg_we_i,
  input  logic [kars_pkg::REG_W-1:0]  cfg_idx_i,
  input  logic [kars_pkg::CFG_W-1:0]  cfg_wdata_i,

  input  logic                        in_valid_i,
  input  logic                        in_ready_i,
  input  logic [kars_pkg::HELD_W-1:0] held_keys_i,

  input  logic                        out_valid_i,
  input  logic                        out_ready_i,
  input  logic [kars_pkg::KEY_W-1:0]  key_index_i,
  input  logic                        event_kind_i,
  input  logic                        last_event_i,

  output int                          error_count_o,
  output int                          pending_o,
  output int                          event_count_o
);

  typedef struct packed {
    logic [kars_pkg::KEY_W-1:0] key_index;
    logic                       event_kind;
    logic                       last_event;
  } key_event_t;

  logic [kars_pkg::CFG_W-1:0]   repeat_delay;
  logic [kars_pkg::CFG_W-1:0]   repeat_rate;
  logic [kars_pkg::HELD_W-1:0]  prev_held;
  logic [kars_pkg::COUNT_W-1:0] hold_count [NUM_KEYS];

  key_event_t expected_events_q [$];
  key_event_t want;
  key_event_t got;
  int         errors;
  int         events_seen;

  // works out the events of one frame and moves the hold counts on
  function automatic void scan_frame(input logic [kars_pkg::HELD_W-1:0] held);
    key_event_t                   ev [NUM_KEYS];
    int                           n;
    logic [kars_pkg::COUNT_W-1:0] d;
    logic [kars_pkg::COUNT_W-1:0] r;
    logic [kars_pkg::COUNT_W-1:0] top_count;
    logic [kars_pkg::COUNT_W-1:0] c;
    n = 0;
    d = kars_pkg::COUNT_W'(repeat_delay);
    r = (repeat_rate == '0) ? kars_pkg::COUNT_W'(1) : kars_pkg::COUNT_W'(repeat_rate);
    top_count = d + r;
    for (int k = 0; k < NUM_KEYS; k++) begin
      if (!held[k]) begin
        if (prev_held[k]) begin
          ev[n] = '{key_index: kars_pkg::KEY_W'(k), event_kind: kars_pkg::EV_RELEASE,
                    last_event: 1'b0};
          n++;
        end
        hold_count[k] = '0;
      end else begin
        c = hold_count[k];
        // first frame of a hold, or the wrapped count hitting delay plus rate
        if (c == '0 || (c > d && c == top_count)) begin
          ev[n] = '{key_index: kars_pkg::KEY_W'(k), event_kind: kars_pkg::EV_PRESS,
                    last_event: 1'b0};
          n++;
        end
        hold_count[k] = (c >= top_count) ? d + kars_pkg::COUNT_W'(1)
                                         : c + kars_pkg::COUNT_W'(1);
      end
    end
    prev_held = held;
    for (int j = 0; j < n; j++) begin
      ev[j].last_event = (j == n - 1);
      expected_events_q.push_back(ev[j]);
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      repeat_delay = kars_pkg::DELAY_RST;
      repeat_rate  = kars_pkg::RATE_RST;
      prev_held    = '0;
      for (int k = 0; k < NUM_KEYS; k++) hold_count[k] = '0;
      expected_events_q.delete();
      errors       = 0;
      events_seen  = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        got = '{key_index: key_index_i, event_kind: event_kind_i, last_event: last_event_i};
        events_seen++;
        if (expected_events_q.size() == 0) begin
          if (errors < 10)
            $display("%t: event key %0d kind %0d last %0d with none expected",
                     $realtime, got.key_index, got.event_kind, got.last_event);
          errors++;
        end else begin
          want = expected_events_q.pop_front();
          if (got.key_index != want.key_index || got.event_kind != want.event_kind ||
              got.last_event != want.last_event) begin
            if (errors < 10)
              $display({"%t: event mismatch: expected key %0d kind %0d last %0d, ",
                        "got key %0d kind %0d last %0d"},
                       $realtime, want.key_index, want.event_kind, want.last_event,
                       got.key_index, got.event_kind, got.last_event);
            errors++;
          end
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == kars_pkg::REG_REPEAT_DELAY) repeat_delay = cfg_wdata_i;
        else if (cfg_idx_i == kars_pkg::REG_REPEAT_RATE) repeat_rate = cfg_wdata_i;
      end
      if (in_valid_i && in_ready_i) scan_frame(held_keys_i);
    end
    error_count_o <= errors;
    pending_o     <= expected_events_q.size();
    event_count_o <= events_seen;
  end

endmodule

// ===== bench/key_auto_repeat_scanner_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// key_auto_repeat_scanner_test: testbench for the key auto-repeat scanner
// Drives held-key frames through a directed opening and several randomised
// phases with different delay and rate settings, keys held across phases, and
// random idling on both channels; the checker beside the block scores events.
// ----------------------------------------------------------------------------
module key_auto_repeat_scanner_test;

  localparam int NUM_KEYS       = kars_pkg::NUM_KEYS_DEF;
  localparam int SETTLE_CYCLES  = NUM_KEYS + 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_FRAMES   = 24;
  localparam int NUM_PHASES     = 7;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [kars_pkg::REG_W-1:0]  cfg_idx = kars_pkg::REG_REPEAT_DELAY;
  logic [kars_pkg::CFG_W-1:0]  cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [kars_pkg::HELD_W-1:0] held_keys = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [kars_pkg::KEY_W-1:0]  key_index;
  logic                        event_kind;
  logic                        last_event;

  int error_count;
  int pending;
  int event_count;

  int                          frames_sent;
  int                          settings_used;
  int                          idle_cycles;
  logic                        tx_burst;
  logic                        rx_burst;
  logic [kars_pkg::HELD_W-1:0] held_now;

  int phase_delay [NUM_PHASES];
  int phase_rate  [NUM_PHASES];

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  key_auto_repeat_scanner #(
    .NUM_KEYS (NUM_KEYS)
  ) DUT (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_we_i     (cfg_we),
    .cfg_idx_i    (cfg_idx),
    .cfg_wdata_i  (cfg_wdata),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .held_keys_i  (held_keys),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .key_index_o  (key_index),
    .event_kind_o (event_kind),
    .last_event_o (last_event)
  );

  key_event_checker #(
    .NUM_KEYS (NUM_KEYS)
  ) u_checker (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .in_valid_i    (in_valid),
    .in_ready_i    (in_ready),
    .held_keys_i   (held_keys),
    .out_valid_i   (out_valid),
    .out_ready_i   (out_ready),
    .key_index_i   (key_index),
    .event_kind_i  (event_kind),
    .last_event_i  (last_event),
    .error_count_o (error_count),
    .pending_o     (pending),
    .event_count_o (event_count)
  );

  // no transfer on either channel for too long means the block has hung
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("simulation failed");
        $finish;
      end
    end
  end

  // event side: random hold-off before each transfer, with bursts of none
  initial begin
    int stall;
    rx_burst = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      stall = rx_burst ? 0 : $urandom_range(0, 15);
      if ($urandom_range(0, 15) == 0) rx_burst = !rx_burst;
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  task automatic send_frame(input logic [kars_pkg::HELD_W-1:0] value);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 15);
    if ($urandom_range(0, 9) == 0) tx_burst = !tx_burst;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    held_keys <= value;
    do @(posedge clk); while (!in_ready);
    held_now = value;
    frames_sent++;
  endtask

  // frames with no events leave the block busy after the last transfer
  task automatic wait_idle();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_config(input int delay_val, input int rate_val);
    cfg_we    <= 1'b1;
    cfg_idx   <= kars_pkg::REG_REPEAT_DELAY;
    cfg_wdata <= kars_pkg::CFG_W'(delay_val);
    @(posedge clk);
    cfg_idx   <= kars_pkg::REG_REPEAT_RATE;
    cfg_wdata <= kars_pkg::CFG_W'(rate_val);
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  initial begin
    logic [kars_pkg::HELD_W-1:0] flip;
    frames_sent   = 0;
    settings_used = 1;
    tx_burst      = 1'b0;
    held_now      = '0;
    phase_delay   = '{1023, 0, 5, 0, 1023, 0, 2};
    phase_rate    = '{1023, 1, 3, 0, 1, 1023, 2};
    phase_delay[3] = $urandom_range(0, 12);
    phase_rate[3]  = $urandom_range(0, 8);

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // default delay and rate: all pressed, all released, alternating patterns
    send_frame('0);
    send_frame('1);
    send_frame('1);
    send_frame('0);
    send_frame(kars_pkg::HELD_W'('h2AAA));
    send_frame(kars_pkg::HELD_W'('h1555));
    send_frame('0);

    // zero rate acts as one: the end keys repeat every frame
    wait_idle();
    set_config(0, 0);
    repeat (4) send_frame(kars_pkg::HELD_W'('h2001));
    send_frame('0);

    // shrink delay plus rate below a held key's count
    wait_idle();
    set_config(4, 2);
    repeat (7) send_frame(kars_pkg::HELD_W'('h0010));
    wait_idle();
    set_config(1, 1);
    repeat (2) send_frame(kars_pkg::HELD_W'('h0010));
    send_frame('0);

    // random phases; keys stay held over the setting changes
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      set_config(phase_delay[p], phase_rate[p]);
      for (int f = 0; f < PHASE_FRAMES; f++) begin
        if ($urandom_range(0, 9) == 0) begin
          send_frame(kars_pkg::HELD_W'($urandom));
        end else begin
          flip = '0;
          for (int k = 0; k < kars_pkg::HELD_W; k++) flip[k] = ($urandom_range(0, 7) == 0);
          send_frame(held_now ^ flip);
        end
      end
    end

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("run covered %0d frames and %0d key events across %0d delay/rate settings",
             frames_sent, event_count, settings_used);
    if (error_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("%0d mismatches, %0d events still outstanding", error_count, pending);
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/kars_pkg.sv
rtl/key_auto_repeat_scanner.sv
bench/key_event_checker.sv
bench/key_auto_repeat_scanner_test.sv
